@@ rtl/core/pcl_pkg.sv @@
// ----------------------------------------------------------------------------
// pcl_pkg
// Types and constants shared by the position correction lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package pcl_pkg;

  localparam int POS_W     = 20;
  localparam int BOUND_W   = 11;
  localparam int DIR_W     = 3;
  localparam int SEL_W     = 3;
  localparam int TIDX_W    = 5;
  localparam int VALUE_W   = 32;
  localparam int ATT_W     = 24;
  localparam int PHASE_W   = 32;
  localparam int FACTOR_W  = 32;
  localparam int AXES      = 3;
  localparam int CFG_IDX_W = 3;

  // reciprocal 2^39 / entry: quotient bits and pipeline split
  localparam int RECIP_Q_W    = 32;
  localparam int RECIP_STAGES = 8;
  localparam int RECIP_STEPS  = RECIP_Q_W / RECIP_STAGES;
  localparam int RECIP_REM_W  = ATT_W + 1;
  // remainder after the eight leading quotient bits, all zero for entries above 128
  localparam logic [RECIP_REM_W-1:0] RECIP_INIT    = RECIP_REM_W'(128);
  localparam logic [ATT_W-1:0]       RECIP_SAT_MAX = ATT_W'(128);

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 32'h0001_0000;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 32'hFFFF_FFFF;
  localparam int DIRECT_SHIFT = 7;
  localparam int DIRECT_W     = ATT_W - DIRECT_SHIFT;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // table_select[2:1] == 3 addresses the phase tables
  localparam logic [1:0] SEL_PHASE = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_X  = 3'd0,
    REG_HIGH_X = 3'd1,
    REG_LOW_Y  = 3'd2,
    REG_HIGH_Y = 3'd3,
    REG_LOW_Z  = 3'd4,
    REG_HIGH_Z = 3'd5,
    REG_DIR    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic                       mode;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic signed [POS_W-1:0]    pos_z;
    logic [SEL_W-1:0]           table_select;
    logic [TIDX_W-1:0]          table_index;
    logic signed [VALUE_W-1:0]  table_value;
  } in_item_t;

  typedef struct packed {
    logic [FACTOR_W-1:0]        attenuation;
    logic signed [PHASE_W-1:0]  phase;
    logic                       index_error;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/pcl_recip.sv @@
// ----------------------------------------------------------------------------
// pcl_recip
// Pipelined restoring divider for floor(2^39 / divisor), low 32 quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_recip (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [pcl_pkg::ATT_W-1:0]           divisor_i,
  output logic      [pcl_pkg::RECIP_Q_W-1:0]       quot_o
);

  localparam int NS = pcl_pkg::RECIP_STAGES;
  localparam int RW = pcl_pkg::RECIP_REM_W;
  localparam int DW = pcl_pkg::ATT_W;
  localparam int QW = pcl_pkg::RECIP_Q_W;

  logic [RW-1:0] rem_q [NS];
  logic [RW-1:0] rem_d [NS];
  logic [DW-1:0] div_q [NS];
  logic [DW-1:0] div_d [NS];
  logic [QW-1:0] quo_q [NS];
  logic [QW-1:0] quo_d [NS];

  always_comb begin
    logic [RW-1:0] r;
    logic [RW-1:0] t;
    logic [DW-1:0] d;
    logic [QW-1:0] q;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        r = pcl_pkg::RECIP_INIT;
        d = divisor_i;
        q = '0;
      end else begin
        r = rem_q[s-1];
        d = div_q[s-1];
        q = quo_q[s-1];
      end
      for (int j = 0; j < pcl_pkg::RECIP_STEPS; j++) begin
        t = {r[RW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          r = t - {1'b0, d};
          q = {q[QW-2:0], 1'b1};
        end else begin
          r = t;
          q = {q[QW-2:0], 1'b0};
        end
      end
      rem_d[s] = r;
      div_d[s] = d;
      quo_d[s] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s] <= rem_d[s];
        div_q[s] <= div_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quot_o = quo_q[NS-1];

endmodule

`default_nettype wire

@@ rtl/core/pml_position_correction_lookup.sv @@
// ----------------------------------------------------------------------------
// pml_position_correction_lookup
// Per-axis border table lookup: attenuation product and phase sum per position.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid_i, in_stall_o, in_item_i    | item into the block
//  out     | out_valid_o, out_stall_i, out_item_o | result out of the block
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i    | register write, no wait
//
//  One item per cycle while the output is not stalled; results pass through the reciprocal divider.
//  Loads and queries stay in order: tables are written and read at one stage.
//  A stalled output holds the whole pipeline; no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pml_position_correction_lookup #(
  parameter int TABLE_DEPTH   = 32,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire pcl_pkg::in_item_t                    in_item_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output pcl_pkg::out_item_t                        out_item_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [pcl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [pcl_pkg::BOUND_W-1:0]          cfg_data_i
);

  localparam int NA     = pcl_pkg::AXES;
  localparam int FB     = FRACTION_BITS;
  localparam int PW     = pcl_pkg::POS_W;
  localparam int BW     = pcl_pkg::BOUND_W;
  localparam int CELL_W = PW - FB + 1;
  localparam int DW     = ((CELL_W > BW + 1) ? CELL_W : BW + 1) + 1;
  localparam int IW     = $clog2(TABLE_DEPTH);
  localparam int MEM_D  = 2 * TABLE_DEPTH;
  localparam int AW     = $clog2(MEM_D);
  localparam int NS     = pcl_pkg::RECIP_STAGES;
  localparam int FW     = pcl_pkg::FACTOR_W;
  localparam int XW     = pcl_pkg::DIRECT_W;
  localparam logic [FB-1:0] QTR  = FB'(1 << (FB - 2));
  localparam logic [FB-1:0] TQTR = FB'(3 << (FB - 2));

  typedef struct packed {
    logic                           mode;
    logic                           err;
    logic [NA-1:0]                  hit;
    logic [NA-1:0]                  inv;
    logic [NA-1:0]                  sat;
    logic [NA-1:0][XW-1:0]          direct;
    logic signed [31:0]             psum;
  } side_t;

  // configuration
  logic [BW-1:0] lo_q [NA];
  logic [BW-1:0] hi_q [NA];
  logic [pcl_pkg::DIR_W-1:0] dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NA; k++) begin
        lo_q[k] <= '0;
        hi_q[k] <= '1;
      end
      dir_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pcl_pkg::REG_LOW_X:  lo_q[0] <= cfg_data_i;
        pcl_pkg::REG_HIGH_X: hi_q[0] <= cfg_data_i;
        pcl_pkg::REG_LOW_Y:  lo_q[1] <= cfg_data_i;
        pcl_pkg::REG_HIGH_Y: hi_q[1] <= cfg_data_i;
        pcl_pkg::REG_LOW_Z:  lo_q[2] <= cfg_data_i;
        pcl_pkg::REG_HIGH_Z: hi_q[2] <= cfg_data_i;
        pcl_pkg::REG_DIR:    dir_q   <= cfg_data_i[pcl_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_q;
  pcl_pkg::out_item_t out_item_q;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign adv         = ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // stage registers
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic [NS-1:0] dlv_q;
  pcl_pkg::in_item_t it1_q, it2_q, it3_q, it4_q;

  logic signed [CELL_W-1:0] cell2_d [NA];
  logic signed [CELL_W-1:0] cell2_q [NA];
  logic [NA-1:0] half2_d, half2_q;

  logic [NA-1:0] half3_q, below3_q, above3_q;
  logic [NA-1:0] below3_d, above3_d;
  logic [DW-1:0] diff3_d [NA];
  logic [DW-1:0] diff3_q [NA];

  logic [NA-1:0] hit4_d, err4_d, inv4_d, hit4_q, err4_q, inv4_q;
  logic [AW-1:0] addr4_d [NA];
  logic [AW-1:0] addr4_q [NA];

  logic [pcl_pkg::ATT_W-1:0]   att_mem [NA][MEM_D];
  logic [pcl_pkg::PHASE_W-1:0] ph_mem  [NA][MEM_D];
  logic [pcl_pkg::ATT_W-1:0]   att5_q  [NA];
  logic [pcl_pkg::PHASE_W-1:0] ph5_q   [NA];
  logic                        mode5_q;
  logic [NA-1:0]               hit5_q, err5_q, inv5_q;

  logic                        mode6_q, err6_q;
  logic [NA-1:0]               hit6_q, inv6_q, sat6_q;
  logic [XW-1:0]               direct6_q [NA];
  logic [pcl_pkg::ATT_W-1:0]   att6_q    [NA];
  logic signed [32:0]          ph6_q     [NA];

  side_t side_d;
  side_t dl_q [NS];
  logic [FW-1:0] quot [NA];

  logic               mode7_q, err7_q;
  logic signed [31:0] psum7_q;
  logic [FW-1:0]      f7_q [NA];
  logic [FW-1:0]      f7_d [NA];

  logic               mode8_q, err8_q, mode9_q, err9_q, mode10_q, err10_q;
  logic signed [31:0] psum8_q, psum9_q, psum10_q;
  logic [2*FW-1:0]    m8_q, m10_q;
  logic [FW-1:0]      fz8_q, fz9_q, p9_q;

  logic signed [PW-1:0] pos1 [NA];
  assign pos1[0] = it1_q.pos_x;
  assign pos1[1] = it1_q.pos_y;
  assign pos1[2] = it1_q.pos_z;

  // floor, round up above three quarters, and classify the fraction
  always_comb begin
    logic [FB-1:0] frac;
    logic          rnd;
    for (int k = 0; k < NA; k++) begin
      frac       = pos1[k][FB-1:0];
      rnd        = frac > TQTR;
      half2_d[k] = (frac >= QTR) && !rnd;
      cell2_d[k] = CELL_W'($signed(pos1[k][PW-1:FB])) + CELL_W'(rnd);
    end
  end

  // compare with the bounds
  always_comb begin
    logic signed [DW-1:0] c, lo, hi;
    for (int k = 0; k < NA; k++) begin
      c  = DW'(cell2_q[k]);
      lo = $signed({{(DW-BW){1'b0}}, lo_q[k]});
      hi = $signed({{(DW-BW){1'b0}}, hi_q[k]});
      below3_d[k] = c < lo;
      above3_d[k] = !below3_d[k] && (half2_q[k] ? (c >= hi) : (c > hi));
      diff3_d[k]  = below3_d[k] ? DW'(lo - c - DW'(half2_q[k])) : DW'(c - hi);
    end
  end

  // table index and direction
  always_comb begin
    logic outside;
    for (int k = 0; k < NA; k++) begin
      outside    = below3_q[k] | above3_q[k];
      err4_d[k]  = outside && (diff3_q[k] >= DW'(TABLE_DEPTH));
      hit4_d[k]  = outside && !err4_d[k];
      inv4_d[k]  = dir_q[k] ? below3_q[k] : !below3_q[k];
      addr4_d[k] = half3_q[k] ? AW'(TABLE_DEPTH) + AW'(diff3_q[k][IW-1:0])
                              : AW'(diff3_q[k][IW-1:0]);
    end
  end

  logic          ld_ok;
  logic [AW-1:0] ld_addr;
  assign ld_ok   = v4_q && (it4_q.mode == pcl_pkg::MODE_LOAD)
                && (9'(it4_q.table_index) < 9'(TABLE_DEPTH));
  assign ld_addr = it4_q.table_select[0] ? AW'(TABLE_DEPTH) + AW'(it4_q.table_index)
                                         : AW'(it4_q.table_index);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NA; k++) begin
        if (ld_ok && it4_q.table_select[2:1] == 2'(k)) begin
          att_mem[k][ld_addr] <= it4_q.table_value[pcl_pkg::ATT_W-1:0];
        end
        if (ld_ok && it4_q.table_select[2:1] == pcl_pkg::SEL_PHASE) begin
          ph_mem[k][ld_addr] <= it4_q.table_value;
        end
        att5_q[k] <= att_mem[k][addr4_q[k]];
        ph5_q[k]  <= ph_mem[k][addr4_q[k]];
      end
    end
  end

  // phase sum and saturation
  always_comb begin
    logic signed [34:0] s;
    s = 35'(ph6_q[0]) + 35'(ph6_q[1]) + 35'(ph6_q[2]);
    side_d.mode = mode6_q;
    side_d.err  = err6_q;
    side_d.hit  = hit6_q;
    side_d.inv  = inv6_q;
    side_d.sat  = sat6_q;
    for (int k = 0; k < NA; k++) begin
      side_d.direct[k] = direct6_q[k];
    end
    if (s > 35'sh0_7FFF_FFFF) begin
      side_d.psum = 32'sh7FFF_FFFF;
    end else if (s < -35'sh0_8000_0000) begin
      side_d.psum = -32'sh8000_0000;
    end else begin
      side_d.psum = s[31:0];
    end
  end

  for (genvar k = 0; k < NA; k++) begin : g_recip
    pcl_recip u_recip (
      .clk_i     (clk_i),
      .en_i      (adv),
      .divisor_i (att6_q[k]),
      .quot_o    (quot[k])
    );
  end

  // factor select
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      if (!dl_q[NS-1].hit[k]) begin
        f7_d[k] = pcl_pkg::FACTOR_ONE;
      end else if (dl_q[NS-1].inv[k]) begin
        f7_d[k] = dl_q[NS-1].sat[k] ? pcl_pkg::FACTOR_MAX : quot[k];
      end else begin
        f7_d[k] = FW'(dl_q[NS-1].direct[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
      dlv_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      dlv_q       <= {dlv_q[NS-2:0], v6_q};
      v7_q        <= dlv_q[NS-1];
      v8_q        <= v7_q;
      v9_q        <= v8_q;
      v10_q       <= v9_q;
      out_valid_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q <= in_item_i;
      it2_q <= it1_q;
      it3_q <= it2_q;
      it4_q <= it3_q;
      half2_q <= half2_d;
      half3_q <= half2_q;
      below3_q <= below3_d;
      above3_q <= above3_d;
      hit4_q <= hit4_d;
      err4_q <= err4_d;
      inv4_q <= inv4_d;
      for (int k = 0; k < NA; k++) begin
        cell2_q[k] <= cell2_d[k];
        diff3_q[k] <= diff3_d[k];
        addr4_q[k] <= addr4_d[k];
      end
      mode5_q <= it4_q.mode;
      hit5_q  <= hit4_q;
      err5_q  <= err4_q;
      inv5_q  <= inv4_q;
      mode6_q <= mode5_q;
      err6_q  <= |err5_q;
      hit6_q  <= hit5_q;
      inv6_q  <= inv5_q;
      for (int k = 0; k < NA; k++) begin
        att6_q[k]    <= att5_q[k];
        direct6_q[k] <= att5_q[k][pcl_pkg::ATT_W-1:pcl_pkg::DIRECT_SHIFT];
        sat6_q[k]    <= att5_q[k] <= pcl_pkg::RECIP_SAT_MAX;
        if (!hit5_q[k]) begin
          ph6_q[k] <= '0;
        end else if (inv5_q[k]) begin
          ph6_q[k] <= -33'($signed(ph5_q[k]));
        end else begin
          ph6_q[k] <= 33'($signed(ph5_q[k]));
        end
      end
      dl_q[0] <= side_d;
      for (int s = 1; s < NS; s++) begin
        dl_q[s] <= dl_q[s-1];
      end
      mode7_q <= dl_q[NS-1].mode;
      err7_q  <= dl_q[NS-1].err;
      psum7_q <= dl_q[NS-1].psum;
      for (int k = 0; k < NA; k++) begin
        f7_q[k] <= f7_d[k];
      end
      mode8_q  <= mode7_q;
      err8_q   <= err7_q;
      psum8_q  <= psum7_q;
      m8_q     <= f7_q[0] * f7_q[1];
      fz8_q    <= f7_q[2];
      mode9_q  <= mode8_q;
      err9_q   <= err8_q;
      psum9_q  <= psum8_q;
      p9_q     <= (m8_q[2*FW-1:FW+16] != '0) ? pcl_pkg::FACTOR_MAX : m8_q[FW+15:16];
      fz9_q    <= fz8_q;
      mode10_q <= mode9_q;
      err10_q  <= err9_q;
      psum10_q <= psum9_q;
      m10_q    <= p9_q * fz9_q;
      if (mode10_q == pcl_pkg::MODE_QUERY) begin
        out_item_q.attenuation <= (m10_q[2*FW-1:FW+16] != '0) ? pcl_pkg::FACTOR_MAX
                                                               : m10_q[FW+15:16];
        out_item_q.phase       <= psum10_q;
        out_item_q.index_error <= err10_q;
      end else begin
        out_item_q <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ test/pcl_lookup_checker.sv @@
// ----------------------------------------------------------------------------
// pcl_lookup_checker
// Watches the item, result and register ports of the position correction
// lookup. It keeps its own copy of the tables and bounds, predicts each
// result and compares it, in order, with what the block delivers.
// ----------------------------------------------------------------------------
module pcl_lookup_checker
  import pcl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BOUND_W-1:0]   cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int FRAC  = 8;

  logic [ATT_W-1:0]   att_mem[6*DEPTH];
  logic [PHASE_W-1:0] ph_mem[2*DEPTH];
  int                 lo_b[AXES];
  int                 hi_b[AXES];
  logic [DIR_W-1:0]   dir;
  out_item_t          expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [31:0] scale_q16(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = ({32'b0, a} * {32'b0, b}) >> 16;
    return (p > 64'hFFFF_FFFF) ? FACTOR_MAX : p[31:0];
  endfunction

  function automatic void axis_corr(input logic signed [POS_W-1:0] pos, input int ax,
                                    output logic [31:0] f, output longint ph,
                                    inout logic err);
    int          cix;
    int          frac;
    bit          half;
    bit          below;
    bit          above;
    longint      idx;
    int          sgn;
    logic [23:0] a;
    longint      q;
    longint      p;
    f = FACTOR_ONE;
    ph = 0;
    half = 0;
    idx = 0;
    frac = pos[FRAC-1:0];
    cix = int'(pos >>> FRAC);
    if (frac > 192) cix++;
    else if (frac >= 64) half = 1;
    below = cix < lo_b[ax];
    if (!half) above = cix > hi_b[ax];
    else above = !below && cix >= hi_b[ax];
    if (below) idx = half ? longint'(lo_b[ax]) - cix - 1 : longint'(lo_b[ax]) - cix;
    else if (above) idx = longint'(cix) - hi_b[ax];
    if (!below && !above) return;
    if (idx < 0 || idx >= DEPTH) begin
      err = 1'b1;
      return;
    end
    sgn = dir[ax] ? 1 : -1;
    if (below) sgn = -sgn;
    a = att_mem[(ax * 2 + int'(half)) * DEPTH + int'(idx)];
    if (sgn > 0) f = 32'(a >> DIRECT_SHIFT);
    else if (a == 0) f = FACTOR_MAX;
    else begin
      q = (longint'(1) << 39) / longint'(a);
      f = (q > 64'sh0_FFFF_FFFF) ? FACTOR_MAX : q[31:0];
    end
    p = longint'($signed(ph_mem[int'(half) * DEPTH + int'(idx)]));
    ph = (sgn < 0) ? -p : p;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t   r;
    logic [31:0] fx, fy, fz;
    longint      px, py, pz, total;
    logic        err;
    r = '0;
    err = 1'b0;
    if (it.mode == MODE_LOAD) begin
      if (it.table_select[2:1] == SEL_PHASE)
        ph_mem[int'(it.table_select[0]) * DEPTH + it.table_index] = it.table_value;
      else
        att_mem[int'(it.table_select) * DEPTH + it.table_index] = it.table_value[ATT_W-1:0];
      return r;
    end
    axis_corr(it.pos_x, 0, fx, px, err);
    axis_corr(it.pos_y, 1, fy, py, err);
    axis_corr(it.pos_z, 2, fz, pz, err);
    total = px + py + pz;
    if (total > 64'sh7FFF_FFFF) total = 64'sh7FFF_FFFF;
    if (total < -64'sh8000_0000) total = -64'sh8000_0000;
    r.attenuation = scale_q16(scale_q16(fx, fy), fz);
    r.phase = total[31:0];
    r.index_error = err;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      errors_o <= 0;
      for (int i = 0; i < AXES; i++) begin
        lo_b[i] = 0;
        hi_b[i] = 2047;
      end
      dir = 3'b111;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LOW_X:  lo_b[0] = cfg_data_i;
          REG_HIGH_X: hi_b[0] = cfg_data_i;
          REG_LOW_Y:  lo_b[1] = cfg_data_i;
          REG_HIGH_Y: hi_b[1] = cfg_data_i;
          REG_LOW_Z:  lo_b[2] = cfg_data_i;
          REG_HIGH_Z: hi_b[2] = cfg_data_i;
          REG_DIR:    dir = cfg_data_i[DIR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result %p", out_item_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_item_i) begin
            if (errors_o < 10)
              $display("mismatch: expected att %h phase %h err %b, got att %h phase %h err %b",
                       want.attenuation, want.phase, want.index_error,
                       out_item_i.attenuation, out_item_i.phase, out_item_i.index_error);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.insert(expected_q.size(), apply_item(in_item_i));
    end
  end

endmodule

@@ test/tb_pml_position_correction_lookup.sv @@
// ----------------------------------------------------------------------------
// tb_pml_position_correction_lookup
// Fills every table, runs directed queries around the region bounds, then
// random loads and queries under several bound and direction settings with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_pml_position_correction_lookup;
  timeunit 1ns;
  timeprecision 1ps;
  import pcl_pkg::*;

  localparam int LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BOUND_W-1:0]   cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  bit                   quiet = 0;
  bit                   hold_req = 0;
  int                   lo_c[AXES];
  int                   hi_c[AXES];

  always #10 clk = ~clk;

  pml_position_correction_lookup uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  pcl_lookup_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    bit held;
    held = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        out_stall <= 1'b0;
        held = 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input in_item_t it);
    bit stalled;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e r, input int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= BOUND_W'(v);
    case (r)
      REG_LOW_X:  lo_c[0] = v;
      REG_HIGH_X: hi_c[0] = v;
      REG_LOW_Y:  lo_c[1] = v;
      REG_HIGH_Y: hi_c[1] = v;
      REG_LOW_Z:  lo_c[2] = v;
      REG_HIGH_Z: hi_c[2] = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_bounds(input int lo, input int hi, input int dirs);
    write_reg(REG_LOW_X, lo);
    write_reg(REG_HIGH_X, hi);
    write_reg(REG_LOW_Y, lo);
    write_reg(REG_HIGH_Y, hi);
    write_reg(REG_LOW_Z, lo);
    write_reg(REG_HIGH_Z, hi);
    write_reg(REG_DIR, dirs);
  endtask

  function automatic in_item_t load_item(int sel, int idx, logic [31:0] v);
    in_item_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.table_select = SEL_W'(sel);
    it.table_index = TIDX_W'(idx);
    it.table_value = v;
    it.pos_x = POS_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t query(int x, int y, int z);
    in_item_t it;
    it = '0;
    it.mode = MODE_QUERY;
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    it.pos_z = POS_W'(z);
    it.table_value = $urandom;
    it.table_select = SEL_W'($urandom);
    return it;
  endfunction

  function automatic int near_bound(int ax);
    int b;
    if ($urandom_range(0, 9) == 0) return int'($urandom);
    b = $urandom_range(0, 1) ? lo_c[ax] : hi_c[ax];
    b = b + int'($urandom_range(0, 80)) - 40;
    return b * 256 + int'($urandom_range(0, 255));
  endfunction

  initial begin
    for (int i = 0; i < AXES; i++) begin
      lo_c[i] = 0;
      hi_c[i] = 2047;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int s = 0; s < 8; s++)
      for (int i = 0; i < 32; i++)
        send(load_item(s, i, $urandom));

    // directed: bounds 100..200
    drain();
    set_bounds(100, 200, 5);
    send(query(150 * 256, 150 * 256, 150 * 256));
    send(query(99 * 256, 99 * 256 + 128, 98 * 256 + 193));
    send(query(201 * 256, 200 * 256 + 128, 202 * 256 + 63));
    send(query(99 * 256 + 64, 99 * 256 + 192, 200 * 256 + 192));
    send(query(300 * 256, 20'sh80000, 20'sh7FFFF));
    send(query(-256, 0, 69 * 256));
    send(load_item(0, 1, 32'h0));
    send(load_item(2, 1, 32'h1));
    send(load_item(4, 1, 32'hFF00_0080));
    send(load_item(1, 0, 32'h00FF_FFFF));
    send(load_item(6, 1, 32'h7FFF_FFFF));
    send(load_item(7, 0, 32'h8000_0000));
    send(query(99 * 256, 99 * 256, 99 * 256));
    send(query(201 * 256, 201 * 256, 201 * 256));
    send(query(99 * 256 + 128, 99 * 256 + 128, 200 * 256 + 128));
    drain();
    write_reg(REG_DIR, 0);
    send(query(99 * 256, 99 * 256, 99 * 256));
    send(query(201 * 256, 201 * 256, 201 * 256));
    send(query(99 * 256 + 128, 99 * 256 + 128, 200 * 256 + 128));

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: set_bounds(0, 2047, 7);
        1: set_bounds(2047, 0, 0);
        default: begin
          write_reg(REG_LOW_X, $urandom_range(0, 2047));
          write_reg(REG_HIGH_X, $urandom_range(0, 2047));
          write_reg(REG_LOW_Y, $urandom_range(0, 2047));
          write_reg(REG_HIGH_Y, $urandom_range(0, 2047));
          write_reg(REG_LOW_Z, $urandom_range(0, 2047));
          write_reg(REG_HIGH_Z, $urandom_range(0, 2047));
          write_reg(REG_DIR, $urandom_range(0, 7));
        end
      endcase
      if (ph == 1) hold_req = 1;
      if (ph == 4) quiet = 1;
      for (int n = 0; n < 55; n++) begin
        if ($urandom_range(0, 4) == 0)
          send(load_item($urandom_range(0, 7), $urandom_range(0, 31), $urandom));
        else
          send(query(near_bound(0), near_bound(1), near_bound(2)));
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/pcl_pkg.sv
rtl/core/pcl_recip.sv
rtl/core/pml_position_correction_lookup.sv
test/pcl_lookup_checker.sv
test/tb_pml_position_correction_lookup.sv
